// ===== rtl/core/log_depth_heatmap_rgb565_macros.svh =====
// Assertion macros shared by the heatmap checker.
// Self-contained; included by any file that carries assertions.
`ifndef LOG_DEPTH_HEATMAP_RGB565_MACROS_SVH
`define LOG_DEPTH_HEATMAP_RGB565_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LDH_ASSERT_NOW(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("ldh same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LDH_ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("ldh next-cycle check failed");

`endif

// ===== rtl/core/ldh_pkg.sv =====
// Package for the log-normalized depth heatmap: widths, codes and the
// elaboration-time builder of the log10 lookup table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ldh_pkg;

  localparam int LOG_FRAC_BITS_DEF  = 14;
  localparam int NORM_FRAC_BITS_DEF = 16;

  localparam int PIX_W   = 8;
  localparam int RGB_W   = 16;
  localparam int USER_W  = 2;
  localparam int ROM_DEPTH = 256;

  // log10(256) is below 4, so two integer bits hold every table entry.
  localparam int LOG_INT_BITS = 2;

  localparam int          LOG2_FRAC      = 28;
  localparam logic [31:0] LOG10_OF_2_Q32 = 32'h4D10_4D42;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  typedef logic [31:0] log_rom_t [ROM_DEPTH];

  // log10(x+1) with fb fraction bits: log2 by repeated mantissa squaring,
  // scaled by log10(2), rounded half-up.
  function automatic logic [31:0] log_entry(int unsigned x, int unsigned fb);
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] l2;
    logic [63:0] prod;
    int unsigned n;
    int unsigned k;
    n = (x & 32'hFF) + 1;
    k = 0;
    for (int j = 0; j < 8; j++) begin
      if ((n >> (k + 1)) != 0) begin
        k = k + 1;
      end
    end
    m = 64'(n) << (31 - k);
    frac = '0;
    for (int i = 0; i < LOG2_FRAC; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    l2 = (64'(k) << LOG2_FRAC) | frac;
    prod = l2 * {32'h0, LOG10_OF_2_Q32};
    return 32'((prod + (64'd1 << (59 - fb))) >> (60 - fb));
  endfunction

  function automatic log_rom_t build_log_rom(int unsigned fb);
    log_rom_t rom;
    for (int x = 0; x < ROM_DEPTH; x++) begin
      rom[x] = log_entry(x, fb);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ldh_div.sv =====
// Radix-2 restoring divider: one quotient bit per cycle, remainder kept
// below the divisor. Uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module ldh_div #(
  parameter int LW = 16,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [LW-1:0] num,
  input  logic [LW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          done
);

  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [LW-1:0] rem;
  logic [LW-1:0] dv;
  logic [LW:0]   shifted;
  logic [LW:0]   diff;
  logic          ge;

  // The numerator is below the divisor, so a doubled remainder stays below
  // twice the divisor and one subtract restores it.
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dv};
  assign ge      = (shifted >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dv  <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? diff[LW-1:0] : shifted[LW-1:0];
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ldh_ramp.sv =====
// Four-segment blue-cyan-green-yellow-red color ramp with RGB565 packing.
// Takes a normalized value with NW fraction bits; uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module ldh_ramp #(
  parameter int NW = 16
) (
  input  logic [NW:0] q,
  output logic [15:0] rgb
);

  localparam int TW = NW + 3;

  localparam logic [1:0] SEG_BLUE_GREEN  = 2'd0;
  localparam logic [1:0] SEG_GREEN_CYAN  = 2'd1;
  localparam logic [1:0] SEG_YELLOW_UP   = 2'd2;
  localparam logic [1:0] SEG_RED_DOWN    = 2'd3;
  localparam logic [7:0] CHAN_MAX        = 8'hFF;

  localparam logic [TW-1:0] ONE_2 = TW'(2) << NW;
  localparam logic [TW-1:0] ONE_4 = TW'(4) << NW;

  logic [1:0]    seg;
  logic [TW-1:0] q4;
  logic [TW-1:0] t_wide;
  logic [NW:0]   t;
  logic [NW+8:0] prod;
  logic [7:0]    lvl;
  logic [7:0]    r;
  logic [7:0]    g;
  logic [7:0]    b;

  assign seg = q[NW] ? SEG_RED_DOWN : q[NW-1:NW-2];
  assign q4  = {q, 2'b00};

  always_comb begin
    case (seg)
      SEG_BLUE_GREEN: t_wide = q4;
      SEG_GREEN_CYAN: t_wide = ONE_2 - q4;
      SEG_YELLOW_UP:  t_wide = q4 - ONE_2;
      SEG_RED_DOWN:   t_wide = ONE_4 - q4;
      default:        t_wide = '0;
    endcase
  end

  // Every segment's ramp term lies in [0, one], so 255*t >> NW fits 8 bits.
  assign t    = t_wide[NW:0];
  assign prod = {t, 8'h00} - {8'h00, t};
  assign lvl  = prod[NW+7:NW];

  always_comb begin
    case (seg)
      SEG_BLUE_GREEN: begin r = '0;       g = lvl;      b = CHAN_MAX; end
      SEG_GREEN_CYAN: begin r = '0;       g = CHAN_MAX; b = lvl;      end
      SEG_YELLOW_UP:  begin r = lvl;      g = CHAN_MAX; b = '0;       end
      SEG_RED_DOWN:   begin r = CHAN_MAX; g = lvl;      b = '0;       end
      default:        begin r = '0;       g = '0;       b = '0;       end
    endcase
  end

  assign rgb = {r[7:3], g[7:2], b[7:3]};

endmodule

`default_nettype wire

// ===== rtl/core/log_depth_heatmap_rgb565.sv =====
// Channel   Dir  Fields (low bit first)
// s_*       in   tdata: pixel[7:0]; tuser: opcode[0], first[1]
// m_*       out  tdata: rgb565[15:0]; tuser: flat
//
// A scan transfer leaves the block idle and ready for another transfer. A
// map transfer holds the input through the load, divide and ramp steps when
// a division is needed, and through the load and ramp steps when the pixel
// saturates or the frame is flat; its result is registered into the output
// register as the ramp step ends. The radix-2 divider makes one quotient bit
// per cycle. Reset clears the frame minimum and maximum to zero, so the frame
// reads as flat until scanned. A result waits in the output register while
// scans go on; a later map stalls in its last step.
`timescale 1ns / 1ps
`default_nettype none

module log_depth_heatmap_rgb565 #(
  parameter int LOG_FRAC_BITS  = ldh_pkg::LOG_FRAC_BITS_DEF,
  parameter int NORM_FRAC_BITS = ldh_pkg::NORM_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ldh_pkg::PIX_W-1:0]  s_tdata,   // pixel
  input  logic [ldh_pkg::USER_W-1:0] s_tuser,   // opcode, first
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ldh_pkg::RGB_W-1:0]  m_tdata,   // rgb565
  output logic                       m_tuser    // flat
);

  import ldh_pkg::*;

  localparam int LW = LOG_FRAC_BITS + LOG_INT_BITS;
  localparam int NW = NORM_FRAC_BITS;
  localparam log_rom_t LOG_ROM = build_log_rom(LOG_FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_RAMP = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    Q_DIV  = 2'd0,
    Q_ZERO = 2'd1,
    Q_ONE  = 2'd2,
    Q_FLAT = 2'd3
  } qsel_t;

  state_t           state;
  state_t           state_next;
  qsel_t            qsel;
  qsel_t            qsel_next;
  logic [PIX_W-1:0] frame_min;
  logic [PIX_W-1:0] frame_max;
  logic [PIX_W-1:0] pix;

  logic             s_xfer;
  logic             op;
  logic             first;
  logic [LW-1:0]    lp;
  logic [LW-1:0]    lmin;
  logic [LW-1:0]    lmax;
  logic [LW-1:0]    num;
  logic [LW-1:0]    den;
  logic             div_start;
  logic             div_done;
  logic [NW-1:0]    quo;
  logic [NW:0]      q_val;
  logic [RGB_W-1:0] rgb;
  logic             out_free;

  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign op       = s_tuser[0];
  assign first    = s_tuser[1];
  assign out_free = !m_tvalid || m_tready;

  assign lp   = LOG_ROM[pix][LW-1:0];
  assign lmin = LOG_ROM[frame_min][LW-1:0];
  assign lmax = LOG_ROM[frame_max][LW-1:0];
  assign num  = lp - lmin;
  assign den  = lmax - lmin;

  always_comb begin
    state_next = state;
    qsel_next  = qsel;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_xfer && op == OP_MAP) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_RAMP;
        // A minimum above the maximum is treated as a flat frame too.
        if (frame_min >= frame_max) begin
          qsel_next = Q_FLAT;
        end else if (lp <= lmin) begin
          qsel_next = Q_ZERO;
        end else if (lp >= lmax) begin
          qsel_next = Q_ONE;
        end else begin
          qsel_next  = Q_DIV;
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_RAMP;
        end
      end
      ST_RAMP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (qsel)
      Q_DIV:   q_val = {1'b0, quo};
      Q_ONE:   q_val = {1'b1, {NW{1'b0}}};
      default: q_val = '0;
    endcase
  end

  ldh_div #(
    .LW (LW),
    .QW (NW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .done  (div_done)
  );

  ldh_ramp #(
    .NW (NW)
  ) u_ramp (
    .q   (q_val),
    .rgb (rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      qsel      <= Q_FLAT;
      frame_min <= '0;
      frame_max <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      qsel  <= qsel_next;
      if (s_xfer && op == OP_SCAN) begin
        if (first) begin
          frame_min <= s_tdata;
          frame_max <= s_tdata;
        end else begin
          if (s_tdata < frame_min) frame_min <= s_tdata;
          if (s_tdata > frame_max) frame_max <= s_tdata;
        end
      end
      if (state == ST_RAMP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      pix <= s_tdata;
    end
    if (state == ST_RAMP && out_free) begin
      m_tdata <= (qsel == Q_FLAT) ? '0 : rgb;
      m_tuser <= (qsel == Q_FLAT);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ldh_checker.sv =====
// Port-level checks for the heatmap block, bound to its top level.
// Depends on the assertion macros header and ldh_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "log_depth_heatmap_rgb565_macros.svh"

module ldh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  import ldh_pkg::*;

  logic s_xfer;
  logic out_stall;

  assign s_xfer    = s_tvalid && s_tready;
  assign out_stall = m_tvalid && !m_tready;

  // A map transfer occupies the engine for at least the following cycle.
  `LDH_ASSERT_NEXT(a_map_busy, clk, rst, s_xfer && s_tuser[0] == OP_MAP, !s_tready)

  // No transfer taken while idle can produce a result in the cycle after it.
  `LDH_ASSERT_NEXT(a_no_fast_result, clk, rst, s_xfer && !m_tvalid, !m_tvalid)

  // A flat frame always yields black.
  `LDH_ASSERT_NOW(a_flat_black, clk, rst, m_tvalid && m_tuser, m_tdata == 16'h0000)

  `LDH_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind log_depth_heatmap_rgb565 ldh_checker u_ldh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
